### rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types and constants of the kinetic scroll engine.
// ----------------------------------------------------------------------------
package kse_pkg;

  // event kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_JITTER_MOVES = 3'd0,
    CFG_MAX_SPEED    = 3'd1,
    CFG_FRICTION     = 3'd2,
    CFG_SCROLL_MIN   = 3'd3,
    CFG_SCROLL_MAX   = 3'd4
  } cfg_idx_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0]  RST_JITTER_MOVES = 4'd4;
  localparam logic [9:0]  RST_MAX_SPEED    = 10'd30;
  localparam logic [7:0]  RST_FRICTION     = 8'd1;
  localparam logic [15:0] RST_SCROLL_MIN   = 16'd0;
  localparam logic [15:0] RST_SCROLL_MAX   = 16'hFFFF;

  // passes granted after a synthetic click
  localparam logic [1:0] PASS_AFTER_CLICK = 2'd2;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic [15:0]        scroll_now;
  } kse_in_t;

  typedef struct packed {
    logic               consumed;
    logic               scroll_valid;
    logic [15:0]        scroll_value;
    logic               click_valid;
    logic signed [15:0] click_x;
    logic signed [15:0] click_y;
  } kse_out_t;

  typedef struct packed {
    logic [3:0]  jitter_moves;
    logic [9:0]  max_speed;
    logic [7:0]  friction;
    logic [15:0] scroll_min;
    logic [15:0] scroll_max;
  } kse_cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               is_button;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        now;
  } kse_cmd_t;

  // clamp a wide signed position to [lo, hi], hi wins on overlap
  function automatic logic [15:0] clamp_scroll(input logic signed [18:0] v,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
    logic signed [18:0] r;
    r = v;
    if (r < $signed({3'b000, lo})) r = $signed({3'b000, lo});
    if (r > $signed({3'b000, hi})) r = $signed({3'b000, hi});
    return r[15:0];
  endfunction

endpackage

### rtl/kinetic_scroll_engine.sv
// ----------------------------------------------------------------------------
// kinetic_scroll_engine
// Kinetic scrolling with friction driven by pointer events and ticks.
// ----------------------------------------------------------------------------
// Path: an input beat is written into the queue entry, then the back stage
//   registers the result.
// Throughput: one beat per cycle unless out_stall holds; each event's math
//   is combinational, limited by the coasting clamp/decay/scroll clamp path.
// Reset: synchronous active-low rst_n clears gesture state, queue and output
//   valid, and loads register defaults; no clearing pass.
module kinetic_scroll_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // event channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kse_pkg::kse_in_t                  in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output kse_pkg::kse_out_t                 out_data,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [kse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [kse_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kse_pkg::*;

  kse_cfg_t cfg_r, cfg_nxt;

  // front -> queue
  logic     q_push, q_full;
  kse_cmd_t q_in;
  // queue -> back
  logic     q_pop, q_not_empty;
  kse_cmd_t q_head;

  // register file; writes to unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_JITTER_MOVES: cfg_nxt.jitter_moves = cfg_wdata[3:0];
        CFG_MAX_SPEED:    cfg_nxt.max_speed    = cfg_wdata[9:0];
        CFG_FRICTION:     cfg_nxt.friction     = cfg_wdata[7:0];
        CFG_SCROLL_MIN:   cfg_nxt.scroll_min   = cfg_wdata;
        CFG_SCROLL_MAX:   cfg_nxt.scroll_max   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jitter_moves <= RST_JITTER_MOVES;
      cfg_r.max_speed    <= RST_MAX_SPEED;
      cfg_r.friction     <= RST_FRICTION;
      cfg_r.scroll_min   <= RST_SCROLL_MIN;
      cfg_r.scroll_max   <= RST_SCROLL_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: takes beats while the queue has room, tags button events
  kse_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // two-entry queue so input and output stall independently
  kse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: gesture state machine and output register
  kse_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### rtl/kse_front.sv
// ----------------------------------------------------------------------------
// kse_front
// Input side: accepts events and classifies them into queue commands.
// ----------------------------------------------------------------------------
module kse_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  kse_pkg::kse_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output kse_pkg::kse_cmd_t q_cmd
);
  import kse_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.kind      = kind_t'(in_data.kind);
    q_cmd.is_button = (in_data.kind == KIND_PRESS) || (in_data.kind == KIND_RELEASE);
    q_cmd.px        = in_data.pointer_x;
    q_cmd.py        = in_data.pointer_y;
    q_cmd.now       = in_data.scroll_now;
  end

endmodule

### rtl/kse_queue.sv
// ----------------------------------------------------------------------------
// kse_queue
// Short command queue decoupling front from back.
// ----------------------------------------------------------------------------
module kse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kse_pkg::kse_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output kse_pkg::kse_cmd_t head
);
  import kse_pkg::*;

  kse_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/kse_back.sv
// ----------------------------------------------------------------------------
// kse_back
// Execution side: gesture state, drag and coasting math, result register.
// ----------------------------------------------------------------------------
module kse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  kse_pkg::kse_cfg_t cfg,
  input  logic              q_not_empty,
  input  kse_pkg::kse_cmd_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output kse_pkg::kse_out_t out_data
);
  import kse_pkg::*;

  logic               held_r, held_nxt;
  logic               dragging_r, dragging_nxt;
  logic signed [15:0] press_x_r, press_x_nxt;
  logic signed [15:0] press_y_r, press_y_nxt;
  logic [15:0]        sap_r, sap_nxt;
  logic signed [15:0] last_y_r, last_y_nxt;
  logic signed [16:0] speed_r, speed_nxt;
  logic [3:0]         jit_r, jit_nxt;
  logic [1:0]         pass_r, pass_nxt;

  logic               out_valid_r;
  kse_out_t           out_r, out_nxt;

  // coasting datapath
  logic signed [16:0] lim17;
  logic signed [11:0] lim12, fr12, sp_clip, sp_dec, sp_abs, sp_fin;
  logic signed [18:0] drag_pos, coast_pos;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    lim12 = $signed({2'b00, cfg.max_speed});
    lim17 = $signed({7'd0, cfg.max_speed});
    fr12  = $signed({4'd0, cfg.friction});

    if (speed_r > lim17)       sp_clip = lim12;
    else if (speed_r < -lim17) sp_clip = -lim12;
    else                       sp_clip = speed_r[11:0];

    if (sp_clip > 12'sd0)      sp_dec = sp_clip - fr12;
    else if (sp_clip < 12'sd0) sp_dec = sp_clip + fr12;
    else                       sp_dec = sp_clip;

    sp_abs = (sp_dec < 12'sd0) ? -sp_dec : sp_dec;
    sp_fin = (sp_abs < fr12) ? 12'sd0 : sp_dec;

    drag_pos  = $signed({3'b000, sap_r})
              - ($signed({{3{q_head.py[15]}}, q_head.py})
                 - $signed({{3{press_y_r[15]}}, press_y_r}));
    coast_pos = $signed({3'b000, q_head.now}) - $signed({{7{sp_fin[11]}}, sp_fin});
  end

  always_comb begin
    held_nxt     = held_r;
    dragging_nxt = dragging_r;
    press_x_nxt  = press_x_r;
    press_y_nxt  = press_y_r;
    sap_nxt      = sap_r;
    last_y_nxt   = last_y_r;
    speed_nxt    = speed_r;
    jit_nxt      = jit_r;
    pass_nxt     = pass_r;

    out_nxt              = '0;
    out_nxt.consumed     = 1'b1;

    if (q_head.is_button && (pass_r != 2'd0)) begin
      pass_nxt         = pass_r - 1'b1;
      out_nxt.consumed = 1'b0;
    end else begin
      case (q_head.kind)
        KIND_PRESS: begin
          held_nxt    = 1'b1;
          press_x_nxt = q_head.px;
          press_y_nxt = q_head.py;
          sap_nxt     = q_head.now;
          if (dragging_r) begin
            dragging_nxt = 1'b0;
            speed_nxt    = '0;
          end
        end
        KIND_MOVE: begin
          if (!dragging_r) begin
            if (jit_r < cfg.jitter_moves) begin
              jit_nxt = jit_r + 1'b1;
            end else begin
              jit_nxt      = '0;
              dragging_nxt = 1'b1;
              last_y_nxt   = q_head.py;
            end
          end else begin
            out_nxt.scroll_valid = 1'b1;
            out_nxt.scroll_value = clamp_scroll(drag_pos, cfg.scroll_min, cfg.scroll_max);
          end
        end
        KIND_RELEASE: begin
          held_nxt = 1'b0;
          if (!dragging_r) begin
            out_nxt.click_valid = 1'b1;
            out_nxt.click_x     = press_x_r;
            out_nxt.click_y     = press_y_r;
            pass_nxt            = PASS_AFTER_CLICK;
          end
        end
        KIND_TICK: begin
          out_nxt.consumed = 1'b0;
          if (held_r && dragging_r) begin
            // sample velocity between ticks
            speed_nxt  = $signed({q_head.py[15], q_head.py})
                       - $signed({last_y_r[15], last_y_r});
            last_y_nxt = q_head.py;
          end else if (!held_r && dragging_r) begin
            speed_nxt = {{5{sp_fin[11]}}, sp_fin};
            if (sp_abs < fr12) dragging_nxt = 1'b0;
            out_nxt.scroll_valid = 1'b1;
            out_nxt.scroll_value = clamp_scroll(coast_pos, cfg.scroll_min, cfg.scroll_max);
          end else begin
            dragging_nxt = 1'b0;
            speed_nxt    = '0;
          end
        end
        default: begin
          out_nxt.consumed = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      dragging_r  <= 1'b0;
      press_x_r   <= '0;
      press_y_r   <= '0;
      sap_r       <= '0;
      last_y_r    <= '0;
      speed_r     <= '0;
      jit_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        held_r     <= held_nxt;
        dragging_r <= dragging_nxt;
        press_x_r  <= press_x_nxt;
        press_y_r  <= press_y_nxt;
        sap_r      <= sap_nxt;
        last_y_r   <= last_y_nxt;
        speed_r    <= speed_nxt;
        jit_r      <= jit_nxt;
        pass_r     <= pass_nxt;
      end
      if (q_pop)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

endmodule
